// ----- design/gbn_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants of the go-back-N sender: operation codes,
// timer request codes, register indexes and the transaction record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package gbn_pkg;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_MESSAGE = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Timer requests reported on the first result of a transaction.
   localparam logic [1:0] TIMER_NONE  = 2'd0;
   localparam logic [1:0] TIMER_START = 2'd1;
   localparam logic [1:0] TIMER_STOP  = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_MESSAGES = 1'b1;
   localparam int CSR_DATA_W = 11;

   // Field widths fixed by the packet format.
   localparam int WINDOW_SIZE_W  = 6;
   localparam int MAX_MESSAGES_W = 11;
   localparam int SEQ_W          = 10;

   // Results per transaction are capped; the counter must hold the cap.
   localparam int MAX_OUT     = 32;
   localparam int OUT_COUNT_W = 6;

   // Widest counter over the supported buffer depths (up to 65536 entries).
   localparam int CNT_MAX_W = 17;

   // Decoupling queue between front end and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_CW    = 2;

   // Classified transaction passed from the front end to the back end.
   typedef struct packed {
      logic [1:0]           op;
      logic                 refused;
      logic [CNT_MAX_W-1:0] count;      // stored message count after this one
      logic                 ack_pass;   // checksum good and number in range
      logic [CNT_MAX_W-1:0] ack_value;
   } gbn_entry_type;

   // Window pointers of the back end.
   typedef struct packed {
      logic [CNT_MAX_W-1:0] base;
      logic [CNT_MAX_W-1:0] next;
   } gbn_status_type;

endpackage

// ----- design/gbn_ram.sv -----
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- design/gbn_front.sv -----
// ----------------------------------------------------------------------------
// gbn_front
// Front end: accepts input transactions, computes packet and ack checksums,
// stores messages in the buffer and queues a classified record.
// ----------------------------------------------------------------------------
module gbn_front #(
   parameter int BUFFER_DEPTH = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_op,
   input  logic [63:0]                     req_payload_low,
   input  logic [63:0]                     req_payload_mid,
   input  logic [31:0]                     req_payload_high,
   input  logic signed [31:0]              req_ack_number,
   input  logic signed [31:0]              req_ack_checksum,
   output logic                            q_push,
   output gbn_pkg::gbn_entry_type          q_entry,
   input  logic                            q_full,
   output logic                            mem_wr_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0] mem_wr_addr,
   output logic [63:0]                     mem_wr_low,
   output logic [63:0]                     mem_wr_mid,
   output logic [63:0]                     mem_wr_high
);
   import gbn_pkg::*;

   localparam int AW    = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_SUM  = 2'd1;
   localparam logic [1:0] F_FOLD = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       op_ff, op_in;
   logic [63:0]      low_ff, low_in;
   logic [63:0]      mid_ff, mid_in;
   logic [31:0]      high_ff, high_in;
   logic [31:0]      ack_num_ff, ack_num_in;
   logic [31:0]      ack_chk_ff, ack_chk_in;
   logic [63:0]      sum_ff, sum_in;
   logic [63:0]      fold_ff, fold_in;

   logic [35:0]      word_sum;
   logic [63:0]      fold_final;
   logic [31:0]      check;
   logic             store_ok;
   logic [CNT_W-1:0] count_plus;

   function automatic logic [35:0] sext36(input logic [31:0] w);
      return {{4{w[31]}}, w};
   endfunction

   // Sum of the seven sign-extended words: sequence, minus one, payload.
   // The exact sum fits in 36 signed bits.
   assign word_sum = 36'(count_ff) + {36{1'b1}}
                   + sext36(low_ff[31:0]) + sext36(low_ff[63:32])
                   + sext36(mid_ff[31:0]) + sext36(mid_ff[63:32])
                   + sext36(high_ff);

   // Second fold step and complement.
   assign fold_final = fold_ff + {16'd0, fold_ff[63:16]};
   assign check      = ~fold_final[31:0];

   assign store_ok   = (op_ff == OP_MESSAGE) && (count_ff < CNT_W'(BUFFER_DEPTH));
   assign count_plus = count_ff + CNT_W'(1);

   // Classified record for the back end.
   always_comb begin
      q_entry.op        = op_ff;
      q_entry.refused   = (op_ff == OP_MESSAGE) && !store_ok;
      q_entry.count     = CNT_MAX_W'(store_ok ? count_plus : count_ff);
      q_entry.ack_pass  = (op_ff == OP_ACK) && (check == ack_chk_ff)
                        && (ack_num_ff[31:CNT_W] == '0);
      q_entry.ack_value = CNT_MAX_W'(ack_num_ff[CNT_W-1:0]);
   end

   // Buffer write: the slot is the current message count.
   assign mem_wr_addr = count_ff[AW-1:0];
   assign mem_wr_low  = low_ff;
   assign mem_wr_mid  = mid_ff;
   assign mem_wr_high = {check, high_ff};

   assign req_stall = reset || (state_ff != F_IDLE);

   // Sequencer: capture, sum, first fold, then push.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      low_in     = low_ff;
      mid_in     = mid_ff;
      high_in    = high_ff;
      ack_num_in = ack_num_ff;
      ack_chk_in = ack_chk_ff;
      sum_in     = sum_ff;
      fold_in    = fold_ff;
      q_push     = 1'b0;
      mem_wr_en  = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               low_in     = req_payload_low;
               mid_in     = req_payload_mid;
               high_in    = req_payload_high;
               ack_num_in = req_ack_number;
               ack_chk_in = req_ack_checksum;
               state_in   = F_SUM;
            end
         end
         F_SUM: begin
            // An ack's checksum covers only the sign-extended ack number.
            if (op_ff == OP_ACK) begin
               sum_in = {{32{ack_num_ff[31]}}, ack_num_ff};
            end else begin
               sum_in = {{28{word_sum[35]}}, word_sum};
            end
            state_in = F_FOLD;
         end
         F_FOLD: begin
            fold_in  = {16'd0, sum_ff[63:16]} + {48'd0, sum_ff[15:0]};
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
               if (store_ok) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_plus;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff      <= op_in;
      low_ff     <= low_in;
      mid_ff     <= mid_in;
      high_ff    <= high_in;
      ack_num_ff <= ack_num_in;
      ack_chk_ff <= ack_chk_in;
      sum_ff     <= sum_in;
      fold_ff    <= fold_in;
   end

endmodule

// ----- design/gbn_queue.sv -----
// ----------------------------------------------------------------------------
// gbn_queue
// Short queue of classified transactions between front end and back end.
// ----------------------------------------------------------------------------
module gbn_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gbn_pkg::gbn_entry_type push_entry,
   input  logic                   pop,
   output gbn_pkg::gbn_entry_type head,
   output logic                   full,
   output logic                   empty
);
   import gbn_pkg::*;

   gbn_entry_type         slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   level_ff, level_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (level_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty   = (level_ff == '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/gbn_back.sv -----
// ----------------------------------------------------------------------------
// gbn_back
// Back end: keeps the send window, applies acknowledgements and produces
// the result transactions, reading stored packets one per cycle while the result output is not stalled.
// ----------------------------------------------------------------------------
module gbn_back #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int WINDOW_MAX   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [gbn_pkg::WINDOW_SIZE_W-1:0]   window_size,
   input  logic [gbn_pkg::MAX_MESSAGES_W-1:0]  max_messages,
   input  gbn_pkg::gbn_entry_type              q_head,
   input  logic                                q_empty,
   output logic                                q_pop,
   output logic                                mem_rd_en,
   output logic [$clog2(BUFFER_DEPTH)-1:0]     mem_rd_addr,
   input  logic [63:0]                         mem_rd_low,
   input  logic [63:0]                         mem_rd_mid,
   input  logic [63:0]                         mem_rd_high,
   output gbn_pkg::gbn_status_type             status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_has_packet,
   output logic [gbn_pkg::SEQ_W-1:0]           rsp_seq_number,
   output logic [63:0]                         rsp_out_payload_low,
   output logic [63:0]                         rsp_out_payload_mid,
   output logic [31:0]                         rsp_out_payload_high,
   output logic signed [31:0]                  rsp_packet_checksum,
   output logic [1:0]                          rsp_timer_action,
   output logic                                rsp_refused,
   output logic                                rsp_last
);
   import gbn_pkg::*;

   localparam int AW    = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MAX_MESSAGES_W ? CNT_W : MAX_MESSAGES_W) + 1;
   localparam int WIN_W = 7;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_EVAL = 2'd1;
   localparam logic [1:0] B_PLAN = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   gbn_entry_type          ent_ff, ent_in;
   logic [CNT_W-1:0]       base_ff, base_in;
   logic [CNT_W-1:0]       next_ff, next_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [OUT_COUNT_W-1:0] n_ff, n_in;
   logic [1:0]             ack_timer_ff, ack_timer_in;
   logic [1:0]             timer_ff, timer_in;
   logic                   first_ff, first_in;
   logic [AW-1:0]          slot_ff, slot_in;

   logic                   valid_ff, valid_in;
   logic                   has_ff, has_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [63:0]            low_ff, low_in;
   logic [63:0]            mid_ff, mid_in;
   logic [31:0]            high_ff, high_in;
   logic [31:0]            chk_ff, chk_in;
   logic [1:0]             tmr_ff, tmr_in;
   logic                   ref_ff, ref_in;
   logic                   last_ff, last_in;

   logic [WIN_W-1:0]       win;
   logic [CMP_W-1:0]       limit;
   logic                   cap_ok;
   logic                   send_more;
   logic                   resend_more;
   logic                   more;
   logic                   is_send;
   logic [CNT_W-1:0]       cur_slot;
   logic [CNT_W-1:0]       ack_val;
   logic [CNT_W-1:0]       ack_plus;
   logic                   ack_hit;
   logic                   out_free;

   // Effective window and the test for one more packet.
   assign win = ({1'b0, window_size} > WIN_W'(WINDOW_MAX)) ? WIN_W'(WINDOW_MAX)
                                                          : {1'b0, window_size};
   assign limit       = CMP_W'(base_ff) + CMP_W'(win);
   assign cap_ok      = n_ff < OUT_COUNT_W'(MAX_OUT);
   assign send_more   = cap_ok && (CMP_W'(next_ff) < limit)
                     && (next_ff < ent_ff.count[CNT_W-1:0])
                     && (CMP_W'(next_ff) < CMP_W'(max_messages));
   assign resend_more = cap_ok && (idx_ff < next_ff);
   assign is_send     = (ent_ff.op == OP_MESSAGE) || (ent_ff.op == OP_ACK);

   always_comb begin
      case (ent_ff.op)
         OP_MESSAGE, OP_ACK: more = send_more;
         OP_TIMEOUT:         more = resend_more;
         default:            more = 1'b0;
      endcase
   end

   assign cur_slot    = (ent_ff.op == OP_TIMEOUT) ? idx_ff : next_ff;
   assign mem_rd_addr = cur_slot[AW-1:0];

   // Acknowledgement window check.
   assign ack_val  = ent_ff.ack_value[CNT_W-1:0];
   assign ack_plus = ack_val + CNT_W'(1);
   assign ack_hit  = (ent_ff.op == OP_ACK) && ent_ff.ack_pass
                  && (ack_val >= base_ff) && (ack_val < next_ff);

   assign out_free = !valid_ff || !rsp_stall;

   // Sequencer: pop, apply ack, plan, then stream packets.
   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      ack_timer_in = ack_timer_ff;
      timer_in     = timer_ff;
      first_in     = first_ff;
      slot_in      = slot_ff;
      q_pop        = 1'b0;
      mem_rd_en    = 1'b0;

      valid_in = valid_ff && rsp_stall;
      has_in   = has_ff;
      seq_in   = seq_ff;
      low_in   = low_ff;
      mid_in   = mid_ff;
      high_in  = high_ff;
      chk_in   = chk_ff;
      tmr_in   = tmr_ff;
      ref_in   = ref_ff;
      last_in  = last_ff;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ent_in   = q_head;
               state_in = B_EVAL;
            end
         end
         B_EVAL: begin
            if (ack_hit) begin
               base_in      = ack_plus;
               ack_timer_in = (ack_plus == next_ff) ? TIMER_STOP : TIMER_START;
            end else begin
               ack_timer_in = TIMER_NONE;
            end
            idx_in   = base_ff;
            n_in     = '0;
            state_in = B_PLAN;
         end
         B_PLAN: begin
            if (more) begin
               // A timeout, or a send that starts with nothing outstanding, restarts the timer.
               if (ent_ff.op == OP_TIMEOUT) begin
                  timer_in = TIMER_START;
               end else if (base_ff == next_ff) begin
                  timer_in = TIMER_START;
               end else begin
                  timer_in = ack_timer_ff;
               end
               mem_rd_en = 1'b1;
               slot_in   = cur_slot[AW-1:0];
               if (is_send) begin
                  next_in = next_ff + CNT_W'(1);
               end else begin
                  idx_in = idx_ff + CNT_W'(1);
               end
               n_in     = n_ff + OUT_COUNT_W'(1);
               first_in = 1'b1;
               state_in = B_OUT;
            end else if (out_free) begin
               // Nothing to send: one empty result closes the transaction.
               valid_in = 1'b1;
               has_in   = 1'b0;
               seq_in   = '0;
               low_in   = '0;
               mid_in   = '0;
               high_in  = '0;
               chk_in   = '0;
               tmr_in   = (ent_ff.op == OP_TIMEOUT) ? TIMER_START : ack_timer_ff;
               ref_in   = ent_ff.refused;
               last_in  = 1'b1;
               state_in = B_IDLE;
            end
         end
         B_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               has_in   = 1'b1;
               seq_in   = SEQ_W'(slot_ff);
               low_in   = mem_rd_low;
               mid_in   = mem_rd_mid;
               high_in  = mem_rd_high[31:0];
               chk_in   = mem_rd_high[63:32];
               tmr_in   = first_ff ? timer_ff : TIMER_NONE;
               ref_in   = first_ff && ent_ff.refused;
               last_in  = !more;
               first_in = 1'b0;
               if (more) begin
                  mem_rd_en = 1'b1;
                  slot_in   = cur_slot[AW-1:0];
                  if (is_send) begin
                     next_in = next_ff + CNT_W'(1);
                  end else begin
                     idx_in = idx_ff + CNT_W'(1);
                  end
                  n_in = n_ff + OUT_COUNT_W'(1);
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         base_ff  <= '0;
         next_ff  <= '0;
         idx_ff   <= '0;
         n_ff     <= '0;
         first_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         next_ff  <= next_in;
         idx_ff   <= idx_in;
         n_ff     <= n_in;
         first_ff <= first_in;
         valid_ff <= valid_in;
      end
      ent_ff       <= ent_in;
      ack_timer_ff <= ack_timer_in;
      timer_ff     <= timer_in;
      slot_ff      <= slot_in;
      has_ff       <= has_in;
      seq_ff       <= seq_in;
      low_ff       <= low_in;
      mid_ff       <= mid_in;
      high_ff      <= high_in;
      chk_ff       <= chk_in;
      tmr_ff       <= tmr_in;
      ref_ff       <= ref_in;
      last_ff      <= last_in;
   end

   assign status.base = CNT_MAX_W'(base_ff);
   assign status.next = CNT_MAX_W'(next_ff);

   assign rsp_valid            = valid_ff;
   assign rsp_has_packet       = has_ff;
   assign rsp_seq_number       = seq_ff;
   assign rsp_out_payload_low  = low_ff;
   assign rsp_out_payload_mid  = mid_ff;
   assign rsp_out_payload_high = high_ff;
   assign rsp_packet_checksum  = chk_ff;
   assign rsp_timer_action     = tmr_ff;
   assign rsp_refused          = ref_ff;
   assign rsp_last             = last_ff;

endmodule

// ----- design/go_back_n_sender_unit.sv -----
// ----------------------------------------------------------------------------
// go_back_n_sender_unit: Go-back-N sender, sender side of the ARQ.
// The checksum front end takes a new transaction only after it has pushed the
// last one to the queue; the back end works through one transaction at a time,
// reading each packet from the buffer, and a stalled result holds it.
// Synchronous reset clears the window, counters and queue; no buffer sweep.
// ----------------------------------------------------------------------------
module go_back_n_sender_unit #(
   parameter int BUFFER_DEPTH = 1024,
   parameter int WINDOW_MAX   = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic [63:0]                        req_payload_low,
   input  logic [63:0]                        req_payload_mid,
   input  logic [31:0]                        req_payload_high,
   input  logic signed [31:0]                 req_ack_number,
   input  logic signed [31:0]                 req_ack_checksum,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_has_packet,
   output logic [9:0]                         rsp_seq_number,
   output logic [63:0]                        rsp_out_payload_low,
   output logic [63:0]                        rsp_out_payload_mid,
   output logic [31:0]                        rsp_out_payload_high,
   output logic signed [31:0]                 rsp_packet_checksum,
   output logic [1:0]                         rsp_timer_action,
   output logic                               rsp_refused,
   output logic                               rsp_last,
   input  logic                               csr_write_enable,
   input  logic [gbn_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import gbn_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic [WINDOW_SIZE_W-1:0]  window_size_ff, window_size_in;
   logic [MAX_MESSAGES_W-1:0] max_messages_ff, max_messages_in;

   gbn_entry_type  push_entry;
   gbn_entry_type  head_entry;
   gbn_status_type status;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_empty;

   logic           mem_wr_en;
   logic [AW-1:0]  mem_wr_addr;
   logic [63:0]    mem_wr_low;
   logic [63:0]    mem_wr_mid;
   logic [63:0]    mem_wr_high;
   logic           mem_rd_en;
   logic [AW-1:0]  mem_rd_addr;
   logic [63:0]    mem_rd_low;
   logic [63:0]    mem_rd_mid;
   logic [63:0]    mem_rd_high;

   // Configuration registers.
   always_comb begin
      window_size_in  = window_size_ff;
      max_messages_in = max_messages_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_SIZE:  window_size_in  = csr_write_data[WINDOW_SIZE_W-1:0];
            CSR_MAX_MESSAGES: max_messages_in = csr_write_data[MAX_MESSAGES_W-1:0];
            default: begin
               window_size_in  = window_size_ff;
               max_messages_in = max_messages_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= WINDOW_SIZE_W'(1);
         max_messages_ff <= MAX_MESSAGES_W'(1024);
      end else begin
         window_size_ff  <= window_size_in;
         max_messages_ff <= max_messages_in;
      end
   end

   // Front end: checksums, message storage, classification.
   gbn_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_payload_low  (req_payload_low),
      .req_payload_mid  (req_payload_mid),
      .req_payload_high (req_payload_high),
      .req_ack_number   (req_ack_number),
      .req_ack_checksum (req_ack_checksum),
      .q_push           (q_push),
      .q_entry          (push_entry),
      .q_full           (q_full),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_low       (mem_wr_low),
      .mem_wr_mid       (mem_wr_mid),
      .mem_wr_high      (mem_wr_high)
   );

   // Queue between the two halves.
   gbn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // Packet buffer: payload low, payload mid, payload high with checksum.
   gbn_ram #(
      .WIDTH (64),
      .DEPTH (BUFFER_DEPTH)
   ) u_store_low (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_low),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_low)
   );

   gbn_ram #(
      .WIDTH (64),
      .DEPTH (BUFFER_DEPTH)
   ) u_store_mid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_mid),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_mid)
   );

   gbn_ram #(
      .WIDTH (64),
      .DEPTH (BUFFER_DEPTH)
   ) u_store_high (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_high),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_high)
   );

   // Back end: window, acknowledgements, result stream.
   gbn_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .WINDOW_MAX   (WINDOW_MAX)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .window_size          (window_size_ff),
      .max_messages         (max_messages_ff),
      .q_head               (head_entry),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .mem_rd_en            (mem_rd_en),
      .mem_rd_addr          (mem_rd_addr),
      .mem_rd_low           (mem_rd_low),
      .mem_rd_mid           (mem_rd_mid),
      .mem_rd_high          (mem_rd_high),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_has_packet       (rsp_has_packet),
      .rsp_seq_number       (rsp_seq_number),
      .rsp_out_payload_low  (rsp_out_payload_low),
      .rsp_out_payload_mid  (rsp_out_payload_mid),
      .rsp_out_payload_high (rsp_out_payload_high),
      .rsp_packet_checksum  (rsp_packet_checksum),
      .rsp_timer_action     (rsp_timer_action),
      .rsp_refused          (rsp_refused),
      .rsp_last             (rsp_last)
   );

   // The window never runs backwards and never exceeds its maximum size.
   a_window_bounds: assert property (@(posedge clock) disable iff (reset)
      (status.next >= status.base)
      && ((status.next - status.base) <= CNT_MAX_W'(WINDOW_MAX)))
      else $error("send window out of bounds");

   // A result without a packet always closes its transaction.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_packet) |-> rsp_last)
      else $error("empty result not marked last");

   // A refused message never comes with a timer stop request.
   a_refused_timer: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_refused) |-> (rsp_timer_action != TIMER_STOP))
      else $error("refused message reported a timer stop");

   // The front end never pushes into a full queue.
   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

endmodule

// ----- tb/gbn_sender_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// gbn_sender_scoreboard_pkg
// Transaction records and the scoreboard of the go-back-N sender testbench.
// The scoreboard keeps its own copy of the window pointers, the message
// store and the registers. For each accepted transaction it works out the
// results the sender owes, and it checks each result against the oldest one.
// ----------------------------------------------------------------------------
package gbn_sender_scoreboard_pkg;

   import gbn_pkg::*;

   // Build parameters of the sender under test.
   localparam int SLOT_COUNT   = 1024;
   localparam int WINDOW_LIMIT = 32;

   // The one operation code the package leaves unnamed.
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   // One input transaction.
   typedef struct {
      logic [1:0]         op;
      logic [63:0]        lo;
      logic [63:0]        mid;
      logic [31:0]        hi;
      logic signed [31:0] ack_number;
      logic signed [31:0] ack_check;
   } sender_req_type;

   // One result transaction.
   typedef struct {
      logic               has_packet;
      logic [9:0]         seq;
      logic [63:0]        lo;
      logic [63:0]        mid;
      logic [31:0]        hi;
      logic signed [31:0] check;
      logic [1:0]         timer;
      logic               refused;
      logic               last;
   } sender_rsp_type;

   class gbn_sender_scoreboard;
      longint base, next_seq, stored;
      int window, max_msgs;
      int errors, transactions, checked, packets, refusals, top_seq;
      logic [63:0] slot_low [SLOT_COUNT];
      logic [63:0] slot_mid [SLOT_COUNT];
      logic [63:0] slot_top [SLOT_COUNT];   // packet checksum above the high payload word
      sender_rsp_type owed[$];
      sender_rsp_type burst[$];
      bit start_req;

      // State right after reset.
      function new();
         base = 0;
         next_seq = 0;
         stored = 0;
         window = 1;
         max_msgs = 1024;
      endfunction

      // Fold a 64-bit sum to 16 bits plus carry and complement it.
      static function logic [31:0] fold_sum(logic [63:0] s);
         logic [63:0] t;
         t = (s >> 16) + (s & 64'hffff);
         t = t + (t >> 16);
         return ~t[31:0];
      endfunction

      static function logic [63:0] widen(logic [31:0] w);
         return {{32{w[31]}}, w};
      endfunction

      static function logic signed [31:0] ack_sum(logic signed [31:0] n);
         return fold_sum(widen(n));
      endfunction

      // Sequence number, the -1 ack field, then five little-endian payload words.
      static function logic [31:0] message_sum(longint slot, logic [63:0] lo,
                                               logic [63:0] mid, logic [31:0] hi);
         return fold_sum(widen(32'(slot)) + widen(32'hffff_ffff) + widen(lo[31:0])
                         + widen(lo[63:32]) + widen(mid[31:0]) + widen(mid[63:32])
                         + widen(hi));
      endfunction

      function void configure(logic [CSR_INDEX_W-1:0] index, int value);
         if (index == CSR_WINDOW_SIZE) window = value & 'h3f;
         else max_msgs = value & 'h7ff;
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      function sender_rsp_type packet_at(longint slot);
         sender_rsp_type r;
         r = '{default: 0};
         r.has_packet = 1'b1;
         r.seq = 10'(slot);
         r.lo = slot_low[slot];
         r.mid = slot_mid[slot];
         r.hi = slot_top[slot][31:0];
         r.check = slot_top[slot][63:32];
         return r;
      endfunction

      // Release stored packets that fit in the window and under the message limit.
      function void release_window();
         longint w;
         w = (window > WINDOW_LIMIT) ? WINDOW_LIMIT : window;
         while (burst.size() < MAX_OUT && next_seq < base + w && next_seq < stored &&
                next_seq < max_msgs) begin
            if (base == next_seq) start_req = 1'b1;
            burst.push_back(packet_at(next_seq));
            next_seq++;
         end
      endfunction

      // Advance the sender by one accepted transaction and queue what it owes.
      function void note_request(sender_req_type it);
         logic [1:0] timer;
         logic refused;
         longint ack;
         longint i;
         sender_rsp_type blank;
         timer = TIMER_NONE;
         refused = 1'b0;
         start_req = 1'b0;
         burst.delete();
         transactions++;
         case (it.op)
            OP_MESSAGE: begin
               if (stored >= SLOT_COUNT) begin
                  refused = 1'b1;
               end else begin
                  slot_low[stored] = it.lo;
                  slot_mid[stored] = it.mid;
                  slot_top[stored] = {message_sum(stored, it.lo, it.mid, it.hi), it.hi};
                  stored++;
               end
               release_window();
               if (start_req) timer = TIMER_START;
            end
            OP_ACK: begin
               ack = longint'(it.ack_number);
               if (ack >= base && ack < next_seq && ack_sum(it.ack_number) == it.ack_check)
               begin
                  base = ack + 1;
                  timer = (base == next_seq) ? TIMER_STOP : TIMER_START;
               end
               release_window();
               // A stop followed by fresh packets collapses into one start.
               if (start_req) timer = TIMER_START;
            end
            OP_TIMEOUT: begin
               timer = TIMER_START;
               for (i = base; i < next_seq && burst.size() < MAX_OUT; i++)
                  burst.push_back(packet_at(i));
            end
            default: ;
         endcase
         if (burst.size() == 0) begin
            blank = '{default: 0};
            burst.push_back(blank);
         end
         burst[0].timer = timer;
         burst[0].refused = refused;
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[k]) owed.push_back(burst[k]);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
         end
      endfunction

      // Match one accepted result against the oldest owed one.
      function void check_response(sender_rsp_type got);
         sender_rsp_type want;
         if (got.has_packet === 1'b1) begin
            packets++;
            if (int'(got.seq) > top_seq) top_seq = int'(got.seq);
         end
         if (got.refused === 1'b1) refusals++;
         if (owed.size() == 0) begin
            $error("result with no transaction pending (seq_number %0d)", got.seq);
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         compare_field("has_packet", want.has_packet, got.has_packet);
         compare_field("seq_number", want.seq, got.seq);
         compare_field("out_payload_low", want.lo, got.lo);
         compare_field("out_payload_mid", want.mid, got.mid);
         compare_field("out_payload_high", want.hi, got.hi);
         compare_field("packet_checksum", want.check, got.check);
         compare_field("timer_action", want.timer, got.timer);
         compare_field("refused", want.refused, got.refused);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

// ----- tb/tb_go_back_n_sender_unit.sv -----
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_unit
// Self-checking testbench of the go-back-N sender. A directed opening covers
// the reset settings, checksum extremes, rejected and sliding acks and the
// timer requests; random phases under several window settings and idling
// patterns follow; a short closing phase with the widest window acks up to
// the newest packet, resends and sends a few fresh messages.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import gbn_pkg::*;
   import gbn_sender_scoreboard_pkg::*;

   // Cycles allowed for the pipeline to go quiet before a register write.
   localparam int SETTLE_CYCLES = 24;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_op = OP_MESSAGE;
   logic [63:0]              req_payload_low = '0;
   logic [63:0]              req_payload_mid = '0;
   logic [31:0]              req_payload_high = '0;
   logic signed [31:0]       req_ack_number = '0;
   logic signed [31:0]       req_ack_checksum = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_has_packet;
   logic [9:0]               rsp_seq_number;
   logic [63:0]              rsp_out_payload_low;
   logic [63:0]              rsp_out_payload_mid;
   logic [31:0]              rsp_out_payload_high;
   logic signed [31:0]       rsp_packet_checksum;
   logic [1:0]               rsp_timer_action;
   logic                     rsp_refused;
   logic                     rsp_last;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   sender_rsp_type seen;
   gbn_sender_scoreboard sb = new();

   go_back_n_sender_unit #(
      .BUFFER_DEPTH(SLOT_COUNT),
      .WINDOW_MAX(WINDOW_LIMIT)
   ) dut (.*);

   // Free-running clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls and a check of every accepted result.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.has_packet = rsp_has_packet;
         seen.seq = rsp_seq_number;
         seen.lo = rsp_out_payload_low;
         seen.mid = rsp_out_payload_mid;
         seen.hi = rsp_out_payload_high;
         seen.check = rsp_packet_checksum;
         seen.timer = rsp_timer_action;
         seen.refused = rsp_refused;
         seen.last = rsp_last;
         sb.check_response(seen);
      end
   end

   // Idling pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 light both.
   function automatic void set_idling(int mode);
      case (mode)
         0: begin idle_pct = 0; stall_pct = 0; end
         1: begin idle_pct = 73; stall_pct = 0; end
         2: begin idle_pct = 0; stall_pct = 73; end
         default: begin idle_pct = 16; stall_pct = 16; end
      endcase
   endfunction

   function automatic sender_req_type make_item(logic [1:0] op, logic [63:0] lo,
                                                logic [63:0] mid, logic [31:0] hi,
                                                logic signed [31:0] n,
                                                logic signed [31:0] c);
      sender_req_type it;
      it.op = op;
      it.lo = lo;
      it.mid = mid;
      it.hi = hi;
      it.ack_number = n;
      it.ack_check = c;
      return it;
   endfunction

   // Mostly well-formed traffic: messages, in-window acks with good checksums,
   // timeouts; the noise share is unknown ops and acks that must be rejected.
   function automatic sender_req_type random_item(int msg_pct, int noise_pct);
      sender_req_type it;
      it = make_item(OP_MESSAGE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                     $urandom, $urandom);
      if ($urandom_range(99) < msg_pct) return it;
      it.op = OP_ACK;
      if ($urandom_range(99) < noise_pct) begin
         case ($urandom_range(4))
            0: it.op = OP_UNKNOWN;
            1: ;
            2: begin
               it.ack_number = 32'(sb.base - 1 - longint'($urandom_range(3)));
               it.ack_check = sb.ack_sum(it.ack_number);
            end
            3: begin
               it.ack_number = 32'(sb.next_seq + longint'($urandom_range(3)));
               it.ack_check = sb.ack_sum(it.ack_number);
            end
            default: begin
               it.ack_number = 32'(sb.base);
               it.ack_check = sb.ack_sum(it.ack_number) ^ (32'h1 << $urandom_range(31));
            end
         endcase
      end else if (sb.next_seq > sb.base && $urandom_range(9) < 8) begin
         // Acking everything is favored so that stop and restart both show up.
         if ($urandom_range(9) < 3) it.ack_number = 32'(sb.next_seq - 1);
         else it.ack_number = $urandom_range(32'(sb.next_seq - 1), 32'(sb.base));
         it.ack_check = sb.ack_sum(it.ack_number);
      end else begin
         it.op = OP_TIMEOUT;
      end
      return it;
   endfunction

   // Present one transaction, hold it until accepted, then book it.
   task automatic drive_item(sender_req_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_payload_low <= it.lo;
      req_payload_mid <= it.mid;
      req_payload_high <= it.hi;
      req_ack_number <= it.ack_number;
      req_ack_checksum <= it.ack_check;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
   endtask

   // Stop sending and wait until the sender has delivered everything owed.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles.
   task automatic set_config(int window_word, int limit_word);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WINDOW_SIZE;
      csr_write_data <= window_word[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_MAX_MESSAGES;
      csr_write_data <= limit_word[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.configure(CSR_WINDOW_SIZE, window_word);
      sb.configure(CSR_MAX_MESSAGES, limit_word);
   endtask

   // Run limit: far beyond a run in which every transaction meets long stalls.
   initial begin
      #4_000_000;
      $display("tb_go_back_n_sender_unit: done, errors");
      $finish;
   end

   initial begin
      int phase;
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: window of one. The ack of the only outstanding packet
      // stops the timer and lets the next one go, which reads as a start.
      drive_item(make_item(OP_UNKNOWN, '1, '1, '1, -1, -1));
      drive_item(make_item(OP_TIMEOUT, '0, '0, '0, '0, '0));
      drive_item(make_item(OP_ACK, '0, '0, '0, 0, sb.ack_sum(0)));
      drive_item(make_item(OP_MESSAGE, '0, '0, '0, '0, '0));
      drive_item(make_item(OP_MESSAGE, '1, '1, '1, '0, '0));
      drive_item(make_item(OP_ACK, '0, '0, '0, 0, sb.ack_sum(0)));

      // Window of four: rejected acks of every kind, then sliding and resends.
      settle();
      set_config(4, 1024);
      drive_item(make_item(OP_ACK, '0, '0, '0, 1, sb.ack_sum(1) ^ 32'h1));
      drive_item(make_item(OP_ACK, '0, '0, '0, 0, sb.ack_sum(0)));
      drive_item(make_item(OP_ACK, '0, '0, '0, 2, sb.ack_sum(2)));
      drive_item(make_item(OP_ACK, '0, '0, '0, -1, sb.ack_sum(-1)));
      drive_item(make_item(OP_ACK, '0, '0, '0, 32'sh8000_0000, sb.ack_sum(32'sh8000_0000)));
      drive_item(make_item(OP_ACK, '0, '0, '0, 32'sh7fff_ffff, sb.ack_sum(32'sh7fff_ffff)));
      drive_item(make_item(OP_MESSAGE, {4{16'haaaa}}, {4{16'haaaa}}, 32'haaaa_aaaa, '0, '0));
      drive_item(make_item(OP_MESSAGE, {4{16'h5555}}, {4{16'h5555}}, 32'h5555_5555, '0, '0));
      drive_item(make_item(OP_MESSAGE, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                           '0, '0));
      drive_item(make_item(OP_MESSAGE, 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff,
                           32'h8000_0001, '0, '0));
      drive_item(make_item(OP_TIMEOUT, '0, '0, '0, '0, '0));
      drive_item(make_item(OP_ACK, '0, '0, '0, 4, sb.ack_sum(4)));
      drive_item(make_item(OP_ACK, '0, '0, '0, 5, sb.ack_sum(5)));
      drive_item(make_item(OP_TIMEOUT, '0, '0, '0, '0, '0));
      drive_item(make_item(OP_UNKNOWN, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                           $urandom, $urandom));

      // Random phases, each under its own register setting and idling pattern.
      for (phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: set_config(($urandom_range(31) << 6) | 1, 1024);
            1: set_config(63, 2047);
            2: set_config(32, int'(sb.stored) + 12);
            3: set_config(0, 1024);
            4: set_config(($urandom_range(31) << 6) | 7, 0);
            default: set_config($urandom_range(31, 1), 1024);
         endcase
         set_idling(phase % 4);
         for (k = 0; k < 56; k++) begin
            // Let the sender drain completely once mid-stream.
            if (phase == 2 && k == 28) settle();
            drive_item(random_item(45, 20));
         end
      end

      // Widest window: ack up to the newest packet, then a resend, a full ack
      // and a few fresh messages.
      settle();
      set_config(32, 1024);
      set_idling(3);
      for (k = 0; k < 16 && sb.next_seq < sb.stored; k++) begin
         if (sb.next_seq > sb.base)
            drive_item(make_item(OP_ACK, '0, '0, '0, 32'(sb.next_seq - 1),
                                 sb.ack_sum(32'(sb.next_seq - 1))));
         else
            drive_item(random_item(100, 0));
      end
      drive_item(make_item(OP_TIMEOUT, '0, '0, '0, '0, '0));
      if (sb.next_seq > sb.base)
         drive_item(make_item(OP_ACK, '0, '0, '0, 32'(sb.next_seq - 1),
                              sb.ack_sum(32'(sb.next_seq - 1))));
      for (k = 0; k < 3; k++) drive_item(random_item(100, 0));
      drive_item(make_item(OP_TIMEOUT, '0, '0, '0, '0, '0));
      drive_item(make_item(OP_UNKNOWN, '0, '0, '0, '0, '0));

      // Drain what is still owed, then leave room for stray results.
      req_valid <= 1'b0;
      for (k = 0; k < 200000 && sb.outstanding() != 0; k++) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d results never arrived", sb.outstanding());
         sb.errors++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d transactions and checked %0d results: %0d packets up to seq %0d,",
               sb.transactions, sb.checked, sb.packets, sb.top_seq);
      $display("%0d refused messages, windows 0 to 63 and message limits 0 to 2047.",
               sb.refusals);
      if (sb.errors == 0)
         $display("tb_go_back_n_sender_unit: done, clean");
      else
         $display("tb_go_back_n_sender_unit: done, errors");
      $finish;
   end

endmodule
